[rtl/gf2lc_pkg.sv]
package gf2lc_pkg;

    localparam int LC_W  = 10;
    localparam int CFG_W = 10;

    localparam logic [CFG_W-1:0] LEN_RESET = 10'd500;

    typedef enum logic
    {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    // commands from the controller to the datapath
    typedef struct packed
    {
        logic accept;
        logic update;
    } dp_cmd_t;

    // status from the datapath to the controller
    typedef struct packed
    {
        logic done;
    } dp_stat_t;

endpackage

[rtl/gf2lc_bit_if.sv]
interface gf2lc_bit_if;

    logic valid;
    logic ready;
    logic data_bit;

    modport source
    (
        output valid,
        output data_bit,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data_bit,
        output ready
    );

endinterface

[rtl/gf2lc_lc_if.sv]
interface gf2lc_lc_if;

    logic                      valid;
    logic                      ready;
    logic [gf2lc_pkg::LC_W-1:0] linear_complexity;

    modport source
    (
        output valid,
        output linear_complexity,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  linear_complexity,
        output ready
    );

endinterface

[rtl/gf2_linear_complexity_blocks.sv]
// results: a result is registered when the word that ends its block is updated (discrepancy
// registered at accept in idle, polynomial update in the update state that follows)
// flow: a word is accepted in idle and updated before the next word is accepted;
// a block end waits in update only while the previous result is not taken
// reset: block length 500, empty block, connection polynomial one, no clearing pass
module gf2_linear_complexity_blocks #(
    parameter int MAX_BLOCK = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gf2lc_pkg::CFG_W-1:0] cfg_data,
    gf2lc_bit_if.sink                   bit_in,
    gf2lc_lc_if.source                  lc_out
);

    gf2lc_pkg::dp_cmd_t  cmd;
    gf2lc_pkg::dp_stat_t stat;

    gf2lc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (bit_in.valid),
        .in_ready  (bit_in.ready),
        .out_valid (lc_out.valid),
        .out_ready (lc_out.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    gf2lc_dp #(
        .MAX_BLOCK (MAX_BLOCK)
    ) u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_data          (cfg_data),
        .data_bit          (bit_in.data_bit),
        .cmd               (cmd),
        .stat              (stat),
        .linear_complexity (lc_out.linear_complexity)
    );

endmodule

[rtl/gf2lc_dp.sv]
module gf2lc_dp #(
    parameter int MAX_BLOCK = 512
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gf2lc_pkg::CFG_W-1:0] cfg_data,
    input  logic                        data_bit,
    input  gf2lc_pkg::dp_cmd_t          cmd,
    output gf2lc_pkg::dp_stat_t         stat,
    output logic [gf2lc_pkg::LC_W-1:0]  linear_complexity
);

    localparam int PW = $clog2(MAX_BLOCK);
    localparam int NW = $clog2(MAX_BLOCK + 1);
    localparam int EW = (NW > gf2lc_pkg::CFG_W) ? NW : gf2lc_pkg::CFG_W;

    localparam logic [MAX_BLOCK-1:0] POLY_ONE  = MAX_BLOCK'(1);
    localparam logic [MAX_BLOCK-1:0] POLY_XONE = MAX_BLOCK'(2);

    logic [gf2lc_pkg::CFG_W-1:0] blk_len_reg;
    logic [MAX_BLOCK-1:0]        bits_reg;
    logic [MAX_BLOCK-1:0]        bits_next;
    logic [MAX_BLOCK-1:0]        conn_reg;
    logic [MAX_BLOCK-1:0]        conn_next;
    logic [MAX_BLOCK-1:0]        pshift_reg;
    logic [MAX_BLOCK-1:0]        pshift_next;
    logic [NW-1:0]               cplx_reg;
    logic [NW-1:0]               cplx_next;
    logic [PW-1:0]               pos_reg;
    logic [PW-1:0]               pos_next;
    logic                        disc_reg;
    logic                        disc_next;
    logic [gf2lc_pkg::LC_W-1:0]  lc_reg;

    logic [EW-1:0]        len_ext;
    logic [NW-1:0]        n_eff;
    logic [MAX_BLOCK-1:0] len_mask;
    logic [NW-1:0]        pos_inc;
    logic                 grow;
    logic [NW-1:0]        cplx_upd;

    // effective block length: zero reads as one, saturate at the store depth
    always_comb
    begin
        len_ext = EW'(blk_len_reg);
        priority if (len_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (len_ext > EW'(MAX_BLOCK))
        begin
            n_eff = NW'(MAX_BLOCK);
        end
        else
        begin
            n_eff = NW'(len_ext);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_BLOCK; i++)
        begin
            len_mask[i] = (NW'(i) < n_eff);
        end
    end

    // bits_reg[i] holds the bit i+1 places back; the discrepancy is taken
    // against the incoming bit before it is shifted in
    assign bits_next = {bits_reg[MAX_BLOCK-2:0], data_bit};
    assign disc_next = data_bit ^ (^(conn_reg[MAX_BLOCK-1:1] & bits_reg[MAX_BLOCK-2:0]));

    assign pos_inc   = NW'(pos_reg) + NW'(1);
    assign stat.done = (pos_inc >= n_eff);

    // pshift_reg keeps the previous polynomial already shifted by the
    // distance since the last length change
    always_comb
    begin
        grow      = ({1'b0, cplx_reg} << 1) <= (NW + 1)'(pos_reg);
        cplx_upd  = cplx_reg;
        conn_next = conn_reg;
        pshift_next = pshift_reg << 1;
        if (disc_reg)
        begin
            conn_next = conn_reg ^ (pshift_reg & len_mask);
            if (grow)
            begin
                cplx_upd    = pos_inc - cplx_reg;
                pshift_next = conn_reg << 1;
            end
        end
        cplx_next = cplx_upd;
        pos_next  = PW'(pos_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_len_reg <= gf2lc_pkg::LEN_RESET;
            bits_reg    <= '0;
            conn_reg    <= POLY_ONE;
            pshift_reg  <= POLY_XONE;
            cplx_reg    <= '0;
            pos_reg     <= '0;
            disc_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                blk_len_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                bits_reg <= bits_next;
                disc_reg <= disc_next;
            end
            else if (cmd.update)
            begin
                if (stat.done)
                begin
                    bits_reg   <= '0;
                    conn_reg   <= POLY_ONE;
                    pshift_reg <= POLY_XONE;
                    cplx_reg   <= '0;
                    pos_reg    <= '0;
                end
                else
                begin
                    conn_reg   <= conn_next;
                    pshift_reg <= pshift_next;
                    cplx_reg   <= cplx_next;
                    pos_reg    <= pos_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && stat.done)
        begin
            lc_reg <= gf2lc_pkg::LC_W'(cplx_next);
        end
    end

    assign linear_complexity = lc_reg;

    a_poly_monic: assert property (@(posedge clk) disable iff (!rst_n)
        conn_reg[0] == 1'b1)
        else $error("connection polynomial lost its constant term");

    a_prev_shifted: assert property (@(posedge clk) disable iff (!rst_n)
        pshift_reg[0] == 1'b0)
        else $error("shifted previous polynomial has a constant term");

    a_cplx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cplx_reg <= NW'(MAX_BLOCK))
        else $error("complexity beyond block store depth");

endmodule

[rtl/gf2lc_ctrl.sv]
module gf2lc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output gf2lc_pkg::dp_cmd_t  cmd,
    input  gf2lc_pkg::dp_stat_t stat
);

    gf2lc_pkg::state_t state_reg;
    gf2lc_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;
    logic              proceed;

    assign out_free = !out_valid_reg || out_ready;
    // a finishing word waits in update until the output slot frees up
    assign proceed  = !stat.done || out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gf2lc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = gf2lc_pkg::ST_UPDATE;
                end
            end
            gf2lc_pkg::ST_UPDATE:
            begin
                if (proceed)
                begin
                    state_next = gf2lc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gf2lc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cmd.accept     = 1'b0;
        cmd.update     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            gf2lc_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            gf2lc_pkg::ST_UPDATE:
            begin
                cmd.update = proceed;
                if (proceed && stat.done)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gf2lc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == gf2lc_pkg::ST_UPDATE))
        else $error("accepted word did not move to update");

    a_result_from_update: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == gf2lc_pkg::ST_UPDATE && stat.done))
        else $error("result raised outside a block end");

    a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == gf2lc_pkg::ST_UPDATE && stat.done && !out_free)
            |=> (state_reg == gf2lc_pkg::ST_UPDATE))
        else $error("block end left update while output slot full");

endmodule

[tb/gf2lc_tb_pkg.sv]
package gf2lc_tb_pkg;

    localparam int DEPTH = 512;

    typedef enum int
    {
        PAT_RANDOM,
        PAT_LFSR,
        PAT_CONST,
        PAT_SPARSE
    } bit_pattern_t;

    class lc_scoreboard;

        bit [gf2lc_pkg::CFG_W-1:0] block_len;
        bit [DEPTH-1:0]            block_bits;
        bit [DEPTH-1:0]            conn_poly;
        bit [DEPTH-1:0]            prev_poly;
        int unsigned               lfsr_len;
        int                        last_change;
        int unsigned               position;
        bit [gf2lc_pkg::LC_W-1:0]  expected_lc[$];
        int unsigned               bits_seen;
        int unsigned               blocks_checked;
        int unsigned               errors;

        function new();
            block_len      = gf2lc_pkg::LEN_RESET;
            bits_seen      = 0;
            blocks_checked = 0;
            errors         = 0;
            clear_block();
        endfunction

        function void clear_block();
            block_bits  = '0;
            conn_poly   = 1;
            prev_poly   = 1;
            lfsr_len    = 0;
            last_change = -1;
            position    = 0;
        endfunction

        function void set_length(bit [gf2lc_pkg::CFG_W-1:0] value);
            block_len = value;
        endfunction

        function int unsigned effective_len();
            if (block_len == 0)
                return 1;
            if (block_len > DEPTH)
                return DEPTH;
            return block_len;
        endfunction

        function int unsigned pending();
            return expected_lc.size();
        endfunction

        // one berlekamp-massey iteration per accepted word
        function void note_bit(bit data);
            int unsigned   n;
            int unsigned   p;
            int unsigned   shift;
            int unsigned   i;
            bit            disc;
            bit [DEPTH-1:0] saved;
            bit [gf2lc_pkg::LC_W-1:0] lc_val;
            n = effective_len();
            p = position;
            if (p >= DEPTH)
                p = DEPTH - 1;
            bits_seen++;
            block_bits[p] = data;
            disc = data;
            for (i = 1; i <= lfsr_len && i <= p; i++)
                disc ^= conn_poly[i] & block_bits[p-i];
            if (disc)
            begin
                shift = int'(p) - last_change;
                saved = conn_poly;
                // update width follows the length in force for this word
                for (i = 0; i + shift < n; i++)
                    conn_poly[i+shift] ^= prev_poly[i];
                if (2 * lfsr_len <= p)
                begin
                    lfsr_len    = p + 1 - lfsr_len;
                    last_change = p;
                    prev_poly   = saved;
                end
            end
            position = p + 1;
            if (position >= n)
            begin
                lc_val = lfsr_len[gf2lc_pkg::LC_W-1:0];
                expected_lc.insert(expected_lc.size(), lc_val);
                clear_block();
            end
        endfunction

        function void check_complexity(logic [gf2lc_pkg::LC_W-1:0] got, time stamp);
            bit [gf2lc_pkg::LC_W-1:0] want;
            if (expected_lc.size() == 0)
            begin
                errors++;
                $display("%0d ns: linear complexity %0d arrived, expected none",
                         stamp, got);
                return;
            end
            want = expected_lc.pop_front();
            blocks_checked++;
            if (got !== want)
            begin
                errors++;
                $display("%0d ns: linear complexity mismatch, expected %0d, actual %0d",
                         stamp, want, got);
            end
        endfunction

    endclass

endpackage

[tb/gf2_linear_complexity_blocks_tb.sv]
module gf2_linear_complexity_blocks_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 6;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_we;
    logic [gf2lc_pkg::CFG_W-1:0] cfg_data;

    gf2lc_bit_if bit_in();
    gf2lc_lc_if  lc_out();

    int                         tx_idle_pct  = 28;
    int                         rx_idle_pct  = 84;
    int                         hold_request = 0;
    int unsigned                writes       = 0;
    gf2lc_tb_pkg::lc_scoreboard lc_sb;

    gf2_linear_complexity_blocks u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .bit_in   (bit_in),
        .lc_out   (lc_out)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, plus a long hold-off when asked for
    initial
    begin
        int unsigned hold_left;
        hold_left    = 0;
        lc_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                lc_out.ready <= 1'b0;
                hold_left--;
            end
            else
                lc_out.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (bit_in.valid && bit_in.ready)
                lc_sb.note_bit(bit_in.data_bit);
            if (lc_out.valid && lc_out.ready)
                lc_sb.check_complexity(lc_out.linear_complexity, $time);
        end
    end

    task automatic send_bit(input bit data);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            bit_in.valid <= 1'b0;
            @(posedge clk);
        end
        bit_in.valid    <= 1'b1;
        bit_in.data_bit <= data;
        do
            @(posedge clk);
        while (!bit_in.ready);
    endtask

    task automatic send_bits(input logic [31:0] pattern, input int unsigned count);
        int unsigned i;
        for (i = count; i > 0; i--)
            send_bit(pattern[i-1]);
    endtask

    task automatic drain_results();
        bit_in.valid <= 1'b0;
        @(posedge clk);
        while (lc_sb.pending() != 0)
            @(posedge clk);
        // a word that ends no block may still be in the datapath
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_length(input int unsigned value);
        drain_results();
        cfg_we   <= 1'b1;
        cfg_data <= value[gf2lc_pkg::CFG_W-1:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        lc_sb.set_length(value[gf2lc_pkg::CFG_W-1:0]);
        writes++;
    endtask

    function automatic gf2lc_tb_pkg::bit_pattern_t pick_pattern();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50)
            return gf2lc_tb_pkg::PAT_LFSR;
        if (r < 80)
            return gf2lc_tb_pkg::PAT_RANDOM;
        if (r < 90)
            return gf2lc_tb_pkg::PAT_CONST;
        return gf2lc_tb_pkg::PAT_SPARSE;
    endfunction

    task automatic send_block_bits(input int unsigned count,
                                   input gf2lc_tb_pkg::bit_pattern_t pattern);
        logic [31:0] sreg;
        logic [31:0] taps;
        logic [31:0] mask;
        int unsigned deg;
        int unsigned i;
        bit          data;
        bit          fill;
        bit          fb;
        deg  = $urandom_range(16, 1);
        mask = (32'h1 << deg) - 1;
        taps = ($urandom | 32'h1) & mask;
        sreg = $urandom & mask;
        if (sreg == 0)
            sreg = 1;
        fill = ($urandom_range(1) != 0);
        for (i = 0; i < count; i++)
        begin
            case (pattern)
                gf2lc_tb_pkg::PAT_LFSR:
                begin
                    data = sreg[0];
                    fb   = ^(sreg & taps);
                    sreg = (sreg >> 1) | ({31'b0, fb} << (deg - 1));
                end
                gf2lc_tb_pkg::PAT_CONST:  data = fill;
                gf2lc_tb_pkg::PAT_SPARSE: data = ($urandom_range(15) == 0);
                default:                  data = ($urandom_range(1) != 0);
            endcase
            send_bit(data);
        end
    endtask

    task automatic run_segment(output int unsigned sent);
        int unsigned r;
        int unsigned len;
        int unsigned n;
        sent = 0;
        r    = $urandom_range(99);
        if (r < 6)
            len = 0;
        else if (r < 12)
            len = 1;
        else if (r < 18)
            len = 2;
        else if (r < 85)
            len = $urandom_range(24, 3);
        else if (r < 97)
            len = $urandom_range(48, 25);
        else
            len = $urandom_range(80, 49);
        write_length(len);
        n = lc_sb.effective_len();
        repeat ((n <= 8) ? $urandom_range(8, 3) : $urandom_range(2, 1))
        begin
            send_block_bits(n, pick_pattern());
            sent += n;
        end
        // leave a partial block behind so the next write lands mid-block
        if (n > 1 && $urandom_range(3) == 0)
        begin
            r = $urandom_range(n - 1, 1);
            send_block_bits(r, pick_pattern());
            sent += r;
        end
    endtask

    task automatic run_mode(input int tx, input int rx, input int unsigned bits);
        int unsigned total;
        int unsigned got;
        tx_idle_pct = tx;
        rx_idle_pct = rx;
        total       = 0;
        while (total < bits)
        begin
            run_segment(got);
            total += got;
        end
    endtask

    initial
    begin
        lc_sb           = new();
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_data        = '0;
        bit_in.valid    = 1'b0;
        bit_in.data_bit = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length of 500 holds until the first write
        send_block_bits(500, gf2lc_tb_pkg::PAT_RANDOM);

        // zero length behaves as one
        write_length(0);
        send_bits(32'b10, 2);
        write_length(1);
        send_bits(32'b01, 2);
        write_length(2);
        send_bits(32'b0111, 4);
        write_length(4);
        send_bits(32'b0001, 4);
        // shrink below the position: next word closes the block
        write_length(8);
        send_bits(32'b11010, 5);
        write_length(3);
        send_bits(32'b1, 1);
        // shrink but stay above the position
        write_length(10);
        send_bits(32'b1001, 4);
        write_length(6);
        send_bits(32'b11, 2);

        run_mode(28, 84, 40);
        run_mode(84, 28, 40);
        run_mode(0, 0, 40);

        // length above the store depth, then cut short mid-block
        write_length(1023);
        send_block_bits(30, gf2lc_tb_pkg::PAT_LFSR);
        write_length(20);
        send_bits(32'b0, 1);

        // long result stall with one result per word fills the output slot and stalls the input
        write_length(1);
        hold_request = 300;
        send_block_bits(16, gf2lc_tb_pkg::PAT_RANDOM);
        drain_results();
        send_block_bits(8, gf2lc_tb_pkg::PAT_SPARSE);
        write_length(2);
        send_block_bits(12, gf2lc_tb_pkg::PAT_LFSR);

        drain_results();
        $display("run covered %0d bits and %0d completed blocks over %0d length writes,",
                 lc_sb.bits_seen, lc_sb.blocks_checked, writes);
        $display("lengths 0 to 1023 with mid-block changes, long result stalls and idle mixes");
        if (lc_sb.errors == 0 && lc_sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
rtl/gf2lc_pkg.sv
rtl/gf2lc_bit_if.sv
rtl/gf2lc_lc_if.sv
rtl/gf2lc_dp.sv
rtl/gf2lc_ctrl.sv
rtl/gf2_linear_complexity_blocks.sv
tb/gf2lc_tb_pkg.sv
tb/gf2_linear_complexity_blocks_tb.sv
